FILE: rtl/core/mhio_pkg.sv
// ----------------------------------------------------------------------------
// mhio_pkg
// Shared widths, codes and types of the hard-iron offset learner.
// ----------------------------------------------------------------------------
`default_nettype none

package mhio_pkg;

   localparam int SampleW  = 13;          // input sample, signed counts
   localparam int OffW     = 21;          // offset and sample, signed Q.8
   localparam int RingW    = 24;          // one ring axis, signed Q.8
   localparam int VecW     = 28;          // working vectors and lengths
   localparam int SqW      = 2 * VecW;    // sum of squares
   localparam int NumW     = 48;          // dividend of the divider
   localparam int CfgW     = 16;          // widest register
   localparam int CsrAddrW = 2;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_LEARN_GAIN   = 2'd0,
      CSR_MIN_CHANGE   = 2'd1,
      CSR_MAX_STEP     = 2'd2,
      CSR_OFFSET_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_READ, S_B1, S_SQ, S_SQRT, S_GMUL, S_GDIV0, S_GDIV,
      S_CORR, S_SMUL, S_SDIV0, S_SDIV, S_APPLY, S_DONE
   } state_type;

   // which vector the length unit is working on
   typedef enum logic [1:0] {
      LEN_DIFF, LEN_B1, LEN_SMP, LEN_CORR
   } len_sel_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [VecW-1:0] mag(input logic signed [VecW-1:0] v);
      return v[VecW-1] ? VecW'(-v) : VecW'(v);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mag_hard_iron_offset_learner.sv
// ----------------------------------------------------------------------------
// mag_hard_iron_offset_learner
// Learns the hard-iron offset of a three-axis magnetometer from its samples.
// ----------------------------------------------------------------------------
// One sample in, one result out carrying the current Q.8 offset vector and a
// flag that says whether this sample moved it. The history ring sits in a
// single synchronous memory; lengths come from a shared two-bits-per-cycle
// square root unit, quotients from a shared one-bit-per-cycle divider, and all
// products from one registered multiplier. The first sample after reset
// fills the ring, and its result is registered after the last entry is written.
// Each length squares the axes of its vector in the multiplier and then
// takes the root. A sample whose difference length is below min_change ends
// after that length without moving the offset. A learning sample takes four
// lengths and a divide for the gain term (the gain divide is skipped when
// the difference length is zero). When the step is limited to max_step,
// three more divides follow, one per axis. One sample is in work at a time;
// a finished result waits in the output register while the next sample is
// taken, and a sample that finishes while that register is still full holds
// in its last state until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module mag_hard_iron_offset_learner #(
   parameter int HISTORY_DEPTH = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [39:0]                       req_tdata,  // mag_x, mag_y, mag_z
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [63:0]                            rsp_tdata,  // offset_x, offset_y, offset_z
   output logic                                   rsp_tuser,  // offset_updated
   input  wire logic                              csr_we,
   input  wire logic [mhio_pkg::CsrAddrW-1:0]     csr_addr,
   input  wire logic [mhio_pkg::CfgW-1:0]         csr_wdata
);

   localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int VecW  = mhio_pkg::VecW;
   localparam int OffW  = mhio_pkg::OffW;
   localparam int RingW = mhio_pkg::RingW;
   localparam int SW    = mhio_pkg::SampleW;
   localparam int NumW  = mhio_pkg::NumW;

   // configuration
   logic [15:0] learn_gain_ff;
   logic [11:0] min_change_ff;
   logic [11:0] max_step_ff;
   logic [11:0] offset_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_gain_ff   <= 16'd655;
         min_change_ff   <= 12'd10;
         max_step_ff     <= 12'd10;
         offset_limit_ff <= 12'd2000;
      end else if (csr_we) begin
         case (mhio_pkg::csr_index_type'(csr_addr))
            mhio_pkg::CSR_LEARN_GAIN:   learn_gain_ff   <= csr_wdata;
            mhio_pkg::CSR_MIN_CHANGE:   min_change_ff   <= csr_wdata[11:0];
            mhio_pkg::CSR_MAX_STEP:     max_step_ff     <= csr_wdata[11:0];
            mhio_pkg::CSR_OFFSET_LIMIT: offset_limit_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // history ring
   logic [3*RingW-1:0] ring_mem [HISTORY_DEPTH];
   logic [3*RingW-1:0] ring_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [3*RingW-1:0] mem_wdata;

   // control and datapath state
   mhio_pkg::state_type   state_ff, state_in;
   mhio_pkg::len_sel_type phase_ff, phase_in;
   logic [1:0]            ax_ff, ax_in;
   logic                  primed_ff, primed_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         fill_ff, fill_in;
   logic signed [OffW-1:0] smp_ff [3], smp_in [3];
   logic signed [OffW-1:0] off_ff [3], off_in [3];
   logic signed [VecW-1:0] b1_ff [3], b1_in [3];
   logic signed [VecW-1:0] diff_ff [3], diff_in [3];
   logic signed [VecW-1:0] corr_ff [3], corr_in [3];
   logic [VecW-1:0]       len_ff, len_in;
   logic [VecW-1:0]       l1_ff, l1_in;
   logic [VecW-1:0]       l2_ff, l2_in;
   logic [VecW-1:0]       clen_ff, clen_in;
   logic [VecW-1:0]       lg_mag_ff, lg_mag_in;
   logic                  lg_neg_ff, lg_neg_in;
   logic [mhio_pkg::SqW-1:0] acc_ff, acc_in;
   logic [mhio_pkg::SqW-1:0] prod_ff;
   logic                  upd_ff, upd_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]           rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tuser_ff, rsp_tuser_in;

   // shared units
   logic [VecW-1:0]       mul_a, mul_b;
   logic                  sq_start, div_start;
   logic [mhio_pkg::SqW-1:0] sq_rad;
   logic [NumW-1:0]       div_num;
   logic [VecW-1:0]       div_den;
   mhio_pkg::unit_stat_type sq_stat, div_stat;
   logic [VecW-1:0]       sq_root;
   logic [NumW-1:0]       div_quo;

   mhio_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   mhio_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   logic [1:0]            ax_idx, ax_prev;
   logic signed [VecW-1:0] vsel;
   logic [VecW-1:0]       min_q, max_q, lim_q;
   logic                  dl_neg;
   logic [VecW-1:0]       dl_mag;
   logic [AW-1:0]         pos_next;
   logic                  req_acc;

   assign ax_idx   = (ax_ff == 2'd3) ? 2'd0 : ax_ff;
   assign ax_prev  = ax_ff - 2'd1;
   assign min_q    = VecW'({min_change_ff, 8'h00});
   assign max_q    = VecW'({max_step_ff, 8'h00});
   assign lim_q    = VecW'({offset_limit_ff, 8'h00});
   assign dl_neg   = l2_ff < l1_ff;
   assign dl_mag   = dl_neg ? (l1_ff - l2_ff) : (l2_ff - l1_ff);
   assign pos_next = (pos_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
   assign req_tready = (state_ff == mhio_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      case (phase_ff)
         mhio_pkg::LEN_DIFF: vsel = diff_ff[ax_idx];
         mhio_pkg::LEN_B1:   vsel = b1_ff[ax_idx];
         mhio_pkg::LEN_SMP:  vsel = VecW'(smp_ff[ax_idx]);
         mhio_pkg::LEN_CORR: vsel = corr_ff[ax_idx];
         default:            vsel = '0;
      endcase
   end

   always_comb begin
      logic signed [VecW:0]   n;
      logic signed [VecW:0]   lim_s;
      logic [VecW-1:0]        cm;
      logic                   cneg;
      state_in      = state_ff;
      phase_in      = phase_ff;
      ax_in         = ax_ff;
      primed_in     = primed_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      smp_in        = smp_ff;
      off_in        = off_ff;
      b1_in         = b1_ff;
      diff_in       = diff_ff;
      corr_in       = corr_ff;
      len_in        = len_ff;
      l1_in         = l1_ff;
      l2_in         = l2_ff;
      clen_in       = clen_ff;
      lg_mag_in     = lg_mag_ff;
      lg_neg_in     = lg_neg_ff;
      acc_in        = acc_ff;
      upd_in        = upd_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mul_a         = '0;
      mul_b         = '0;
      sq_start      = 1'b0;
      sq_rad        = acc_ff + prod_ff;
      div_start     = 1'b0;
      div_num       = prod_ff[NumW-1:0];
      div_den       = (state_ff == mhio_pkg::S_GDIV0) ? len_ff : clen_ff;
      lim_s         = (VecW+1)'(lim_q);
      n             = '0;
      cm            = '0;
      cneg          = 1'b0;
      for (int i = 0; i < 3; i++) begin
         mem_wdata[i*RingW +: RingW] = RingW'(smp_ff[i]) - RingW'(off_ff[i]);
      end

      case (state_ff)
         mhio_pkg::S_IDLE: begin
            if (req_acc) begin
               for (int i = 0; i < 3; i++) begin
                  smp_in[i] = {req_tdata[i*SW +: SW], 8'h00};
               end
               fill_in  = '0;
               state_in = primed_ff ? mhio_pkg::S_READ : mhio_pkg::S_FILL;
            end
         end
         mhio_pkg::S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            fill_in   = fill_ff + 1'b1;
            if (fill_ff == AW'(HISTORY_DEPTH - 1)) begin
               primed_in = 1'b1;
               pos_in    = '0;
               upd_in    = 1'b0;
               state_in  = mhio_pkg::S_DONE;
            end
         end
         mhio_pkg::S_READ: state_in = mhio_pkg::S_B1;
         mhio_pkg::S_B1: begin
            for (int i = 0; i < 3; i++) begin
               b1_in[i]   = VecW'($signed(ring_rd_ff[i*RingW +: RingW])) +
                            VecW'(off_ff[i]);
               diff_in[i] = VecW'(smp_ff[i]) - b1_in[i];
            end
            phase_in = mhio_pkg::LEN_DIFF;
            ax_in    = 2'd0;
            state_in = mhio_pkg::S_SQ;
         end
         mhio_pkg::S_SQ: begin
            // one square per cycle, accumulate the registered product
            mul_a  = mhio_pkg::mag(vsel);
            mul_b  = mhio_pkg::mag(vsel);
            acc_in = (ax_ff == 2'd0) ? '0 : acc_ff + prod_ff;
            ax_in  = ax_ff + 2'd1;
            if (ax_ff == 2'd3) begin
               sq_start = 1'b1;
               state_in = mhio_pkg::S_SQRT;
            end
         end
         mhio_pkg::S_SQRT: begin
            if (sq_stat.done) begin
               ax_in = 2'd0;
               case (phase_ff)
                  mhio_pkg::LEN_DIFF: begin
                     len_in = sq_root;
                     pos_in = pos_next;
                     if (sq_root < min_q) begin
                        upd_in   = 1'b0;
                        state_in = mhio_pkg::S_DONE;
                     end else begin
                        mem_we   = 1'b1;
                        phase_in = mhio_pkg::LEN_B1;
                        state_in = mhio_pkg::S_SQ;
                     end
                  end
                  mhio_pkg::LEN_B1: begin
                     l1_in    = sq_root;
                     phase_in = mhio_pkg::LEN_SMP;
                     state_in = mhio_pkg::S_SQ;
                  end
                  mhio_pkg::LEN_SMP: begin
                     l2_in = sq_root;
                     if (len_ff == '0) begin
                        lg_mag_in = '0;
                        lg_neg_in = 1'b0;
                        state_in  = mhio_pkg::S_CORR;
                     end else begin
                        state_in  = mhio_pkg::S_GMUL;
                     end
                  end
                  default: begin
                     clen_in  = sq_root;
                     state_in = (sq_root > max_q) ? mhio_pkg::S_SMUL
                                                  : mhio_pkg::S_APPLY;
                  end
               endcase
            end
         end
         mhio_pkg::S_GMUL: begin
            mul_a    = VecW'(learn_gain_ff);
            mul_b    = dl_mag;
            state_in = mhio_pkg::S_GDIV0;
         end
         mhio_pkg::S_GDIV0: begin
            div_start = 1'b1;
            state_in  = mhio_pkg::S_GDIV;
         end
         mhio_pkg::S_GDIV: begin
            if (div_stat.done) begin
               lg_mag_in = div_quo[VecW-1:0];
               lg_neg_in = dl_neg;
               ax_in     = 2'd0;
               state_in  = mhio_pkg::S_CORR;
            end
         end
         mhio_pkg::S_CORR: begin
            // issue diff * gain term, store the previous axis, drop 16 bits
            mul_a = mhio_pkg::mag(diff_ff[ax_idx]);
            mul_b = lg_mag_ff;
            ax_in = ax_ff + 2'd1;
            if (ax_ff != 2'd0) begin
               cm   = prod_ff[VecW+15:16];
               cneg = diff_ff[ax_prev][VecW-1] ^ lg_neg_ff;
               corr_in[ax_prev] = cneg ? VecW'(-$signed(cm)) : $signed(cm);
            end
            if (ax_ff == 2'd3) begin
               ax_in    = 2'd0;
               phase_in = mhio_pkg::LEN_CORR;
               state_in = mhio_pkg::S_SQ;
            end
         end
         mhio_pkg::S_SMUL: begin
            mul_a    = mhio_pkg::mag(corr_ff[ax_idx]);
            mul_b    = max_q;
            state_in = mhio_pkg::S_SDIV0;
         end
         mhio_pkg::S_SDIV0: begin
            div_start = 1'b1;
            state_in  = mhio_pkg::S_SDIV;
         end
         mhio_pkg::S_SDIV: begin
            if (div_stat.done) begin
               cm   = div_quo[VecW-1:0];
               cneg = corr_ff[ax_idx][VecW-1];
               corr_in[ax_idx] = cneg ? VecW'(-$signed(cm)) : $signed(cm);
               ax_in    = ax_ff + 2'd1;
               state_in = (ax_ff == 2'd2) ? mhio_pkg::S_APPLY : mhio_pkg::S_SMUL;
            end
         end
         mhio_pkg::S_APPLY: begin
            for (int i = 0; i < 3; i++) begin
               n = (VecW+1)'(off_ff[i]) - (VecW+1)'(corr_ff[i]);
               if (n > lim_s) n = lim_s;
               if (n < -lim_s) n = -lim_s;
               off_in[i] = OffW'(n);
            end
            upd_in   = 1'b1;
            state_in = mhio_pkg::S_DONE;
         end
         mhio_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, off_ff[2], off_ff[1], off_ff[0]};
               rsp_tuser_in  = upd_ff;
               state_in      = mhio_pkg::S_IDLE;
            end
         end
         default: state_in = mhio_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mhio_pkg::S_IDLE;
         primed_ff     <= 1'b0;
         pos_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) off_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         primed_ff     <= primed_in;
         pos_ff        <= pos_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         off_ff        <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      ax_ff        <= ax_in;
      fill_ff      <= fill_in;
      smp_ff       <= smp_in;
      b1_ff        <= b1_in;
      diff_ff      <= diff_in;
      corr_ff      <= corr_in;
      len_ff       <= len_in;
      l1_ff        <= l1_in;
      l2_ff        <= l2_in;
      clen_ff      <= clen_in;
      lg_mag_ff    <= lg_mag_in;
      lg_neg_ff    <= lg_neg_in;
      acc_ff       <= acc_in;
      prod_ff      <= mul_a * mul_b;
      upd_ff       <= upd_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
      ring_rd_ff <= ring_mem[pos_ff];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < (AW+1)'(HISTORY_DEPTH))
      else $error("ring position out of range");

   a_fill_first: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !primed_ff) |=> (state_ff == mhio_pkg::S_FILL))
      else $error("first sample did not fill the ring");

   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(primed_ff))
      else $error("primed dropped outside reset");

   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_stat.busy)
      else $error("square root started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: rtl/core/mhio_sqrt.sv
// ----------------------------------------------------------------------------
// mhio_sqrt
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhio_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [mhio_pkg::SqW-1:0]    radicand,
   output mhio_pkg::unit_stat_type          stat,
   output logic [mhio_pkg::VecW-1:0]        root
);

   localparam int Steps = mhio_pkg::VecW;
   localparam int CntW  = $clog2(Steps);
   localparam int RemW  = mhio_pkg::VecW + 2;

   logic                        busy_ff;
   logic                        done_ff;
   logic [CntW-1:0]             cnt_ff;
   logic [mhio_pkg::SqW-1:0]    rad_ff;
   logic [RemW-1:0]             rem_ff;
   logic [mhio_pkg::VecW-1:0]   root_ff;
   logic [RemW+1:0]             rem_sh;
   logic [RemW+1:0]             trial;
   logic                        take;

   assign rem_sh = {rem_ff, rad_ff[mhio_pkg::SqW-1 -: 2]};
   assign trial  = (RemW+2)'({root_ff, 2'b01});
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(Steps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[mhio_pkg::SqW-3:0], 2'b00};
         rem_ff  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
         root_ff <= {root_ff[mhio_pkg::VecW-2:0], take};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mhio_div.sv
// ----------------------------------------------------------------------------
// mhio_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhio_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [mhio_pkg::NumW-1:0]   dividend,
   input  wire logic [mhio_pkg::VecW-1:0]   divisor,
   output mhio_pkg::unit_stat_type          stat,
   output logic [mhio_pkg::NumW-1:0]        quotient
);

   localparam int Steps = mhio_pkg::NumW;
   localparam int CntW  = $clog2(Steps);
   localparam int RemW  = mhio_pkg::VecW + 1;

   logic                        busy_ff;
   logic                        done_ff;
   logic [CntW-1:0]             cnt_ff;
   logic [mhio_pkg::NumW-1:0]   num_ff;
   logic [mhio_pkg::NumW-1:0]   quo_ff;
   logic [mhio_pkg::VecW-1:0]   den_ff;
   logic [mhio_pkg::VecW-1:0]   rem_ff;
   logic [RemW-1:0]             rem_sh;
   logic                        take;

   assign rem_sh = {rem_ff, num_ff[mhio_pkg::NumW-1]};
   assign take   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(Steps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[mhio_pkg::NumW-2:0], 1'b0};
         rem_ff <= take ? mhio_pkg::VecW'(rem_sh - {1'b0, den_ff})
                        : mhio_pkg::VecW'(rem_sh);
         quo_ff <= {quo_ff[mhio_pkg::NumW-2:0], take};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire
